// ===== design/ltl_pkg.sv =====
`default_nettype none

package ltl_pkg;

  localparam int CH_W            = 16;
  localparam int LUX_W           = 19;
  localparam int LUX_FRAC_BITS   = 8;
  localparam int RATIO_FRAC_BITS = 12;
  localparam int POW_TABLE_DEPTH = 64;
  localparam int POW_FRAC        = 16;
  localparam int POW_W           = POW_FRAC + 1;
  localparam int COEF_FRAC       = 24;
  localparam int KB_W            = 20;

  localparam logic [LUX_W-1:0] LUX_MAX = {LUX_W{1'b1}};

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = ((LUX_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 3;

  // lux coefficients, q24
  localparam logic [KB_W-1:0] K_B1_A = KB_W'(510028);
  localparam logic [KB_W-1:0] K_B1_B = KB_W'(1040187);
  localparam logic [KB_W-1:0] K_B2_A = KB_W'(375810);
  localparam logic [KB_W-1:0] K_B2_B = KB_W'(520094);
  localparam logic [KB_W-1:0] K_B3_A = KB_W'(214748);
  localparam logic [KB_W-1:0] K_B3_B = KB_W'(256691);
  localparam logic [KB_W-1:0] K_B4_A = KB_W'(24495);
  localparam logic [KB_W-1:0] K_B4_B = KB_W'(18790);

  // band limits as ch1 * C1 <= ch0 * C0
  localparam int CMP_W       = CH_W + 7;
  localparam int LIM_LOW_C1  = 2;
  localparam int LIM_LOW_C0  = 1;
  localparam int LIM_MID_C1  = 100;
  localparam int LIM_MID_C0  = 61;
  localparam int LIM_HIGH_C1 = 5;
  localparam int LIM_HIGH_C0 = 4;
  localparam int LIM_TOP_C1  = 10;
  localparam int LIM_TOP_C0  = 13;

  localparam int DIV_STAGES = RATIO_FRAC_BITS;
  localparam int POS_W      = RATIO_FRAC_BITS + $clog2(2 * POW_TABLE_DEPTH);
  localparam int IDX_W      = POS_W - RATIO_FRAC_BITS;
  localparam int TI_W       = $clog2(POW_TABLE_DEPTH + 1);
  localparam int PA_W       = KB_W + CH_W;
  localparam int BP_W       = KB_W + POW_W;
  localparam int PR_W       = CH_W + BP_W;
  localparam int SH_LOW     = COEF_FRAC + POW_FRAC - LUX_FRAC_BITS;
  localparam int SH_LIN     = COEF_FRAC - LUX_FRAC_BITS;

  // pipeline stage positions
  localparam int ST_IN = 0;
  localparam int ST_SA = DIV_STAGES + 1;
  localparam int ST_SB = DIV_STAGES + 2;
  localparam int ST_SC = DIV_STAGES + 3;
  localparam int ST_SD = DIV_STAGES + 4;
  localparam int ST_SE = DIV_STAGES + 5;
  localparam int ST_SF = DIV_STAGES + 6;
  localparam int NST   = DIV_STAGES + 7;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  typedef enum logic [2:0] {
    BAND_NONE = 3'd0,
    BAND_LOW  = 3'd1,
    BAND_MID  = 3'd2,
    BAND_HIGH = 3'd3,
    BAND_TOP  = 3'd4
  } band_t;

  typedef logic [POW_TABLE_DEPTH:0][POW_W-1:0] pow_tab_t;

  function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
    return (a * b) >> 30;
  endfunction

  function automatic logic [63:0] q30_pow5(input logic [63:0] y);
    logic [63:0] y2;
    logic [63:0] y4;
    y2 = q30_mul(y, y);
    y4 = q30_mul(y2, y2);
    return q30_mul(y4, y);
  endfunction

  function automatic logic [63:0] q30_root5(input logic [63:0] v);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    lo = '0;
    hi = Q30_ONE;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 64'd1) >> 1);
      if (q30_pow5(mid) <= v) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    return lo;
  endfunction

  // entry i is (i / (2 * depth))^1.4 in q16
  function automatic pow_tab_t build_pow_tab();
    pow_tab_t    tab;
    logic [63:0] x;
    logic [63:0] r;
    tab = '0;
    for (int i = 0; i <= POW_TABLE_DEPTH; i++) begin
      x = (64'(i) << 30) / (2 * POW_TABLE_DEPTH);
      r = q30_root5(q30_mul(x, x));
      tab[i] = POW_W'(q30_mul(x, r) >> (30 - POW_FRAC));
    end
    return tab;
  endfunction

  localparam pow_tab_t POW_TAB = build_pow_tab();

endpackage

`default_nettype wire

// ===== design/ltl_div.sv =====
`default_nettype none

module ltl_div (
  input  wire logic                                 clk,
  input  wire logic [ltl_pkg::DIV_STAGES-1:0]       en,
  input  wire logic [ltl_pkg::CH_W-1:0]             ch0_in,
  input  wire logic [ltl_pkg::CH_W-1:0]             ch1_in,
  input  wire ltl_pkg::band_t                       band_in,
  output logic      [ltl_pkg::RATIO_FRAC_BITS-1:0]  rq_out,
  output logic      [ltl_pkg::CH_W-1:0]             ch0_out,
  output logic      [ltl_pkg::CH_W-1:0]             ch1_out,
  output ltl_pkg::band_t                            band_out
);

  localparam int N  = ltl_pkg::DIV_STAGES;
  localparam int W  = ltl_pkg::CH_W;
  localparam int QW = ltl_pkg::RATIO_FRAC_BITS;

  logic [W-1:0]    rem_r  [N];
  logic [QW-1:0]   q_r    [N];
  logic [W-1:0]    ch0_r  [N];
  logic [W-1:0]    ch1_r  [N];
  ltl_pkg::band_t  band_r [N];

  // one quotient bit per stage, remainder stays below ch0 while ch1 is below ch0
  for (genvar k = 0; k < N; k++) begin : g_step
    logic [W-1:0]   rem_in;
    logic [QW-1:0]  q_in;
    logic [W-1:0]   ch0_in_k;
    logic [W-1:0]   ch1_in_k;
    ltl_pkg::band_t band_in_k;
    logic [W:0]     rem_sh;
    logic [W:0]     rem_sub;
    logic           take;
    logic [W-1:0]   rem_nxt;
    logic [QW-1:0]  q_nxt;

    if (k == 0) begin : g_first
      assign rem_in    = ch1_in;
      assign q_in      = '0;
      assign ch0_in_k  = ch0_in;
      assign ch1_in_k  = ch1_in;
      assign band_in_k = band_in;
    end else begin : g_next
      assign rem_in    = rem_r[k-1];
      assign q_in      = q_r[k-1];
      assign ch0_in_k  = ch0_r[k-1];
      assign ch1_in_k  = ch1_r[k-1];
      assign band_in_k = band_r[k-1];
    end

    assign rem_sh  = {rem_in, 1'b0};
    assign take    = rem_sh >= {1'b0, ch0_in_k};
    assign rem_sub = rem_sh - {1'b0, ch0_in_k};
    assign rem_nxt = take ? rem_sub[W-1:0] : rem_sh[W-1:0];
    assign q_nxt   = {q_in[QW-2:0], take};

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k]  <= rem_nxt;
        q_r[k]    <= q_nxt;
        ch0_r[k]  <= ch0_in_k;
        ch1_r[k]  <= ch1_in_k;
        band_r[k] <= band_in_k;
      end
    end
  end

  assign rq_out   = q_r[N-1];
  assign ch0_out  = ch0_r[N-1];
  assign ch1_out  = ch1_r[N-1];
  assign band_out = band_r[N-1];

endmodule

`default_nettype wire

// ===== design/two_channel_light_to_lux_unit.sv =====
// throughput: one word per cycle while the output is not stalled
// stages are the input register, 12 one-bit divider stages for the ch1/ch0 ratio, table
// read, interpolation, a multiply, a clamped subtract, another multiply and the output
// a stall only holds stages that are full, so bubbles are squeezed out upstream
// reset: synchronous active-low rst_n clears all stage valid bits, data is not reset
`default_nettype none

module two_channel_light_to_lux_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // raw_byte0 [7:0], raw_byte1 [15:8], raw_byte2 [23:16], raw_byte3 [31:24]
  input  wire logic [ltl_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // lux_value [18:0], zero fill [23:19]
  output logic      [ltl_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // ratio_band [2:0]
  output logic      [ltl_pkg::OUT_TUSER_W-1:0]   out_tuser
);

  localparam int NST  = ltl_pkg::NST;
  localparam int W    = ltl_pkg::CH_W;
  localparam int RFB  = ltl_pkg::RATIO_FRAC_BITS;
  localparam int PW   = ltl_pkg::POW_W;
  localparam int MULW = PW + RFB;

  logic [NST-1:0] vld_r;
  logic [NST-1:0] vld_nxt;
  logic [NST-1:0] vld_in;
  logic [NST-1:0] en;

  // stage valid bits and per-stage advance
  always_comb begin
    vld_in = {vld_r[NST-2:0], in_tvalid};
    for (int k = 0; k < NST; k++) begin
      en[k] = out_tready | ~&(vld_r | NST'((64'd1 << k) - 64'd1));
    end
    vld_nxt = vld_r;
    for (int k = 0; k < NST; k++) begin
      if (en[k]) begin
        vld_nxt[k] = vld_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready  = en[ltl_pkg::ST_IN];
  assign out_tvalid = vld_r[ltl_pkg::ST_SF];

  // input stage: channels and band
  logic [W-1:0]             c0;
  logic [W-1:0]             c1;
  logic [ltl_pkg::CMP_W-1:0] c0w;
  logic [ltl_pkg::CMP_W-1:0] c1w;
  ltl_pkg::band_t           band_nxt;
  logic [W-1:0]             ch0_s0_r;
  logic [W-1:0]             ch1_s0_r;
  ltl_pkg::band_t           band_s0_r;

  assign c0  = {in_tdata[7:0], in_tdata[15:8]};
  assign c1  = {in_tdata[31:24], in_tdata[23:16]};
  assign c0w = ltl_pkg::CMP_W'(c0);
  assign c1w = ltl_pkg::CMP_W'(c1);

  always_comb begin
    band_nxt = ltl_pkg::BAND_NONE;
    if (c0 != '0 && c1 != '0) begin
      if (ltl_pkg::CMP_W'(ltl_pkg::LIM_LOW_C1) * c1w <=
          ltl_pkg::CMP_W'(ltl_pkg::LIM_LOW_C0) * c0w) begin
        band_nxt = ltl_pkg::BAND_LOW;
      end else if (ltl_pkg::CMP_W'(ltl_pkg::LIM_MID_C1) * c1w <=
                   ltl_pkg::CMP_W'(ltl_pkg::LIM_MID_C0) * c0w) begin
        band_nxt = ltl_pkg::BAND_MID;
      end else if (ltl_pkg::CMP_W'(ltl_pkg::LIM_HIGH_C1) * c1w <=
                   ltl_pkg::CMP_W'(ltl_pkg::LIM_HIGH_C0) * c0w) begin
        band_nxt = ltl_pkg::BAND_HIGH;
      end else if (ltl_pkg::CMP_W'(ltl_pkg::LIM_TOP_C1) * c1w <=
                   ltl_pkg::CMP_W'(ltl_pkg::LIM_TOP_C0) * c0w) begin
        band_nxt = ltl_pkg::BAND_TOP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ltl_pkg::ST_IN]) begin
      ch0_s0_r  <= c0;
      ch1_s0_r  <= c1;
      band_s0_r <= band_nxt;
    end
  end

  // ratio divider
  logic [RFB-1:0]  div_rq;
  logic [W-1:0]    div_ch0;
  logic [W-1:0]    div_ch1;
  ltl_pkg::band_t  div_band;

  ltl_div u_div (
    .clk      (clk),
    .en       (en[ltl_pkg::DIV_STAGES:1]),
    .ch0_in   (ch0_s0_r),
    .ch1_in   (ch1_s0_r),
    .band_in  (band_s0_r),
    .rq_out   (div_rq),
    .ch0_out  (div_ch0),
    .ch1_out  (div_ch1),
    .band_out (div_band)
  );

  // stage a: table read, linear band products
  logic [ltl_pkg::POS_W-1:0] pos;
  logic [ltl_pkg::IDX_W-1:0] idx;
  logic [ltl_pkg::TI_W-1:0]  lo_i;
  logic [ltl_pkg::TI_W-1:0]  hi_i;
  logic [PW-1:0]             lo_nxt;
  logic [PW-1:0]             hi_v;
  logic [PW-1:0]             diff_nxt;
  logic [ltl_pkg::KB_W-1:0]  ka;
  logic [ltl_pkg::KB_W-1:0]  kb;
  logic [ltl_pkg::PA_W-1:0]  pa_nxt;
  logic [ltl_pkg::PA_W-1:0]  pb_nxt;

  logic [W-1:0]              sa_ch0_r;
  ltl_pkg::band_t            sa_band_r;
  logic [PW-1:0]             sa_lo_r;
  logic [PW-1:0]             sa_diff_r;
  logic [RFB-1:0]            sa_fr_r;
  logic [ltl_pkg::PA_W-1:0]  sa_pa_r;
  logic [ltl_pkg::PA_W-1:0]  sa_pb_r;

  assign pos  = ltl_pkg::POS_W'(div_rq) * ltl_pkg::POS_W'(2 * ltl_pkg::POW_TABLE_DEPTH);
  assign idx  = pos[ltl_pkg::POS_W-1:RFB];
  assign lo_i = idx[ltl_pkg::TI_W-1:0];
  assign hi_i = lo_i + 1'b1;

  always_comb begin
    hi_v = '0;
    if (idx >= ltl_pkg::IDX_W'(ltl_pkg::POW_TABLE_DEPTH)) begin
      lo_nxt   = ltl_pkg::POW_TAB[ltl_pkg::POW_TABLE_DEPTH];
      diff_nxt = '0;
    end else begin
      lo_nxt   = ltl_pkg::POW_TAB[lo_i];
      hi_v     = ltl_pkg::POW_TAB[hi_i];
      diff_nxt = (hi_v > lo_nxt) ? hi_v - lo_nxt : '0;
    end
  end

  always_comb begin
    case (div_band)
      ltl_pkg::BAND_MID: begin
        ka = ltl_pkg::K_B2_A;
        kb = ltl_pkg::K_B2_B;
      end
      ltl_pkg::BAND_HIGH: begin
        ka = ltl_pkg::K_B3_A;
        kb = ltl_pkg::K_B3_B;
      end
      ltl_pkg::BAND_TOP: begin
        ka = ltl_pkg::K_B4_A;
        kb = ltl_pkg::K_B4_B;
      end
      default: begin
        ka = '0;
        kb = '0;
      end
    endcase
  end

  assign pa_nxt = ltl_pkg::PA_W'(ka) * ltl_pkg::PA_W'(div_ch0);
  assign pb_nxt = ltl_pkg::PA_W'(kb) * ltl_pkg::PA_W'(div_ch1);

  always_ff @(posedge clk) begin
    if (en[ltl_pkg::ST_SA]) begin
      sa_ch0_r  <= div_ch0;
      sa_band_r <= div_band;
      sa_lo_r   <= lo_nxt;
      sa_diff_r <= diff_nxt;
      sa_fr_r   <= pos[RFB-1:0];
      sa_pa_r   <= pa_nxt;
      sa_pb_r   <= pb_nxt;
    end
  end

  // stage b: interpolation, linear band difference
  logic [MULW-1:0]           interp;
  logic [PW-1:0]             p_nxt;
  logic [ltl_pkg::PA_W-1:0]  acc_nxt;
  logic [W-1:0]              sb_ch0_r;
  ltl_pkg::band_t            sb_band_r;
  logic [PW-1:0]             sb_p_r;
  logic [ltl_pkg::PA_W-1:0]  sb_acc_r;

  assign interp  = (MULW'(sa_diff_r) * MULW'(sa_fr_r)) >> RFB;
  assign p_nxt   = sa_lo_r + interp[PW-1:0];
  assign acc_nxt = (sa_pa_r > sa_pb_r) ? sa_pa_r - sa_pb_r : '0;

  always_ff @(posedge clk) begin
    if (en[ltl_pkg::ST_SB]) begin
      sb_ch0_r  <= sa_ch0_r;
      sb_band_r <= sa_band_r;
      sb_p_r    <= p_nxt;
      sb_acc_r  <= acc_nxt;
    end
  end

  // stage c: b coefficient times r^1.4
  logic [ltl_pkg::BP_W-1:0]  bp_nxt;
  logic [W-1:0]              sc_ch0_r;
  ltl_pkg::band_t            sc_band_r;
  logic [ltl_pkg::BP_W-1:0]  sc_bp_r;
  logic [ltl_pkg::PA_W-1:0]  sc_acc_r;

  assign bp_nxt = ltl_pkg::BP_W'(ltl_pkg::K_B1_B) * ltl_pkg::BP_W'(sb_p_r);

  always_ff @(posedge clk) begin
    if (en[ltl_pkg::ST_SC]) begin
      sc_ch0_r  <= sb_ch0_r;
      sc_band_r <= sb_band_r;
      sc_bp_r   <= bp_nxt;
      sc_acc_r  <= sb_acc_r;
    end
  end

  // stage d: low band coefficient, clamped at zero
  logic [ltl_pkg::BP_W-1:0]  a1s;
  logic [ltl_pkg::BP_W-1:0]  coef_nxt;
  logic [W-1:0]              sd_ch0_r;
  ltl_pkg::band_t            sd_band_r;
  logic [ltl_pkg::BP_W-1:0]  sd_coef_r;
  logic [ltl_pkg::PA_W-1:0]  sd_acc_r;

  assign a1s      = ltl_pkg::BP_W'(ltl_pkg::K_B1_A) << ltl_pkg::POW_FRAC;
  assign coef_nxt = (a1s > sc_bp_r) ? a1s - sc_bp_r : '0;

  always_ff @(posedge clk) begin
    if (en[ltl_pkg::ST_SD]) begin
      sd_ch0_r  <= sc_ch0_r;
      sd_band_r <= sc_band_r;
      sd_coef_r <= coef_nxt;
      sd_acc_r  <= sc_acc_r;
    end
  end

  // stage e: ch0 times coefficient
  logic [ltl_pkg::PR_W-1:0]  prod_nxt;
  ltl_pkg::band_t            se_band_r;
  logic [ltl_pkg::PR_W-1:0]  se_prod_r;
  logic [ltl_pkg::PA_W-1:0]  se_acc_r;

  assign prod_nxt = ltl_pkg::PR_W'(sd_ch0_r) * ltl_pkg::PR_W'(sd_coef_r);

  always_ff @(posedge clk) begin
    if (en[ltl_pkg::ST_SE]) begin
      se_band_r <= sd_band_r;
      se_prod_r <= prod_nxt;
      se_acc_r  <= sd_acc_r;
    end
  end

  // stage f: scale, saturate, output register
  logic [ltl_pkg::PR_W-1:0]  sh_low;
  logic [ltl_pkg::PA_W-1:0]  sh_lin;
  logic [ltl_pkg::LUX_W-1:0] lux_nxt;
  logic [ltl_pkg::LUX_W-1:0] out_lux_r;
  ltl_pkg::band_t            out_band_r;

  assign sh_low = se_prod_r >> ltl_pkg::SH_LOW;
  assign sh_lin = se_acc_r >> ltl_pkg::SH_LIN;

  always_comb begin
    case (se_band_r)
      ltl_pkg::BAND_LOW: begin
        lux_nxt = (sh_low > ltl_pkg::PR_W'(ltl_pkg::LUX_MAX)) ? ltl_pkg::LUX_MAX
                                                            : sh_low[ltl_pkg::LUX_W-1:0];
      end
      ltl_pkg::BAND_MID, ltl_pkg::BAND_HIGH, ltl_pkg::BAND_TOP: begin
        lux_nxt = (sh_lin > ltl_pkg::PA_W'(ltl_pkg::LUX_MAX)) ? ltl_pkg::LUX_MAX
                                                            : sh_lin[ltl_pkg::LUX_W-1:0];
      end
      default: begin
        lux_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[ltl_pkg::ST_SF]) begin
      out_lux_r  <= lux_nxt;
      out_band_r <= se_band_r;
    end
  end

  assign out_tdata = ltl_pkg::OUT_TDATA_W'(out_lux_r);
  assign out_tuser = ltl_pkg::OUT_TUSER_W'(out_band_r);

  logic in_acc;
  logic out_acc;

  assign in_acc  = in_tvalid & in_tready;
  assign out_acc = out_tvalid & out_tready;

  a_word_count: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> $countones(vld_r) ==
              $past($countones(vld_r)) + int'($past(in_acc)) - int'($past(out_acc)))
    else $error("stage valid count does not match accepted and delivered words");

  a_ready_on_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    !(&vld_r) |-> in_tready)
    else $error("input stalled while a stage is empty");

  a_zero_band_input: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ltl_pkg::ST_IN] && (ch0_s0_r == '0 || ch1_s0_r == '0) |->
      band_s0_r == ltl_pkg::BAND_NONE)
    else $error("zero channel given a ratio band");

  a_zero_band_lux: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_band_r == ltl_pkg::BAND_NONE |-> out_lux_r == '0)
    else $error("nonzero lux with no ratio band");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH     = 64;
  localparam int RATIO_Q   = 12;
  localparam int LUX_Q     = 8;
  localparam int COEF_Q    = 24;
  localparam int SHIFT_LOW = COEF_Q + 16 - LUX_Q;
  localparam int SHIFT_LIN = COEF_Q - LUX_Q;
  localparam int N_RANDOM  = 1530;

  localparam bit [63:0] LUX_CAP = 64'd524287;

  // q24 lux coefficients per band
  localparam bit [63:0] CF_B1_A = 64'd510028;
  localparam bit [63:0] CF_B1_B = 64'd1040187;
  localparam bit [63:0] CF_B2_A = 64'd375810;
  localparam bit [63:0] CF_B2_B = 64'd520094;
  localparam bit [63:0] CF_B3_A = 64'd214748;
  localparam bit [63:0] CF_B3_B = 64'd256691;
  localparam bit [63:0] CF_B4_A = 64'd24495;
  localparam bit [63:0] CF_B4_B = 64'd18790;

  typedef struct {
    logic [ltl_pkg::LUX_W-1:0] lux;
    ltl_pkg::band_t            band;
  } lux_result_t;

  class lux_scoreboard;
    bit [31:0]   pow_q16 [0:DEPTH];
    lux_result_t pending_q [$];
    int          errors;

    function new();
      bit [63:0] x;
      bit [63:0] sq;
      bit [63:0] lo;
      bit [63:0] hi;
      bit [63:0] mid;
      bit [63:0] y2;
      bit [63:0] y4;
      errors = 0;
      // ratio^1.4 as x * fifth root of x^2, all in q30
      for (int i = 0; i <= DEPTH; i++) begin
        x  = (64'(i) << 30) / (2 * DEPTH);
        sq = q30_product(x, x);
        lo = 64'd0;
        hi = 64'd1 << 30;
        while (lo < hi) begin
          mid = lo + (hi - lo + 64'd1) / 2;
          y2  = q30_product(mid, mid);
          y4  = q30_product(y2, y2);
          if (q30_product(y4, mid) <= sq) begin
            lo = mid;
          end else begin
            hi = mid - 64'd1;
          end
        end
        pow_q16[i] = 32'(q30_product(x, lo) >> 14);
      end
    endfunction

    function bit [63:0] q30_product(bit [63:0] a, bit [63:0] b);
      return (a * b) >> 30;
    endfunction

    function logic [ltl_pkg::LUX_W-1:0] settle_lux(bit [63:0] pos_part, bit [63:0] neg_part,
                                                   int shift);
      bit [63:0] v;
      if (neg_part >= pos_part) begin
        return '0;
      end
      v = (pos_part - neg_part) >> shift;
      return (v > LUX_CAP) ? LUX_CAP[ltl_pkg::LUX_W-1:0] : v[ltl_pkg::LUX_W-1:0];
    endfunction

    function void note_sample(logic [31:0] word);
      bit [63:0]   ch0;
      bit [63:0]   ch1;
      bit [63:0]   rq;
      bit [63:0]   pos;
      bit [63:0]   idx;
      bit [63:0]   fr;
      bit [63:0]   lo;
      bit [63:0]   hi;
      bit [63:0]   p;
      lux_result_t want;
      ch0       = {48'd0, word[7:0], word[15:8]};
      ch1       = {48'd0, word[31:16]};
      want.lux  = '0;
      want.band = ltl_pkg::BAND_NONE;
      if (ch0 != 0 && ch1 != 0) begin
        if (2 * ch1 <= ch0) begin
          rq  = (ch1 << RATIO_Q) / ch0;
          pos = rq * 2 * DEPTH;
          idx = pos >> RATIO_Q;
          fr  = pos & ((64'd1 << RATIO_Q) - 64'd1);
          if (idx >= DEPTH) begin
            p = pow_q16[DEPTH];
          end else begin
            lo = pow_q16[idx];
            hi = pow_q16[idx + 1];
            if (hi < lo) begin
              hi = lo;
            end
            p = lo + (((hi - lo) * fr) >> RATIO_Q);
          end
          want.band = ltl_pkg::BAND_LOW;
          want.lux  = settle_lux((ch0 * CF_B1_A) << 16, ch0 * CF_B1_B * p, SHIFT_LOW);
        end else if (100 * ch1 <= 61 * ch0) begin
          want.band = ltl_pkg::BAND_MID;
          want.lux  = settle_lux(CF_B2_A * ch0, CF_B2_B * ch1, SHIFT_LIN);
        end else if (5 * ch1 <= 4 * ch0) begin
          want.band = ltl_pkg::BAND_HIGH;
          want.lux  = settle_lux(CF_B3_A * ch0, CF_B3_B * ch1, SHIFT_LIN);
        end else if (10 * ch1 <= 13 * ch0) begin
          want.band = ltl_pkg::BAND_TOP;
          want.lux  = settle_lux(CF_B4_A * ch0, CF_B4_B * ch1, SHIFT_LIN);
        end
      end
      pending_q.push_back(want);
    endfunction

    function void check_result(logic [ltl_pkg::LUX_W-1:0] lux,
                               logic [ltl_pkg::OUT_TUSER_W-1:0] band);
      lux_result_t want;
      if (pending_q.size() == 0) begin
        $error("lux word with no sample pending: lux_value %0d ratio_band %0d", lux, band);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (lux !== want.lux) begin
        $error("lux_value mismatch: expected %0d, actual %0d", want.lux, lux);
        errors++;
      end
      if (band !== want.band) begin
        $error("ratio_band mismatch: expected %0d, actual %0d", want.band, band);
        errors++;
      end
    endfunction
  endclass

  logic                                 clk        = 1'b0;
  logic                                 rst_n      = 1'b0;
  logic                                 in_tvalid  = 1'b0;
  logic [ltl_pkg::IN_TDATA_W-1:0]       in_tdata   = '0;
  logic                                 out_tready = 1'b0;
  wire logic                            in_tready;
  wire logic                            out_tvalid;
  wire logic [ltl_pkg::OUT_TDATA_W-1:0] out_tdata;
  wire logic [ltl_pkg::OUT_TUSER_W-1:0] out_tuser;

  lux_scoreboard sb;
  bit            tx_steady;

  two_channel_light_to_lux_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [31:0] sample_word(int unsigned ch0, int unsigned ch1);
    return {ch1[15:0], ch0[7:0], ch0[15:8]};
  endfunction

  function automatic logic [31:0] random_sample();
    int          ch0;
    int          ch1;
    int          pick;
    int          num;
    int          den;
    pick = $urandom_range(0, 3);
    if (pick == 0) begin
      ch0 = $urandom_range(0, 16);
    end else if (pick == 1) begin
      ch0 = $urandom_range(1, 255);
    end else begin
      ch0 = $urandom_range(1, 65535);
    end
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      return $urandom();
    end else if (pick < 8) begin
      ch1 = (ch0 * $urandom_range(0, 1400)) / 1000;
    end else begin
      // straddle one of the band limits
      case ($urandom_range(0, 3))
        0:       begin num = 1;  den = 2;   end
        1:       begin num = 61; den = 100; end
        2:       begin num = 4;  den = 5;   end
        default: begin num = 13; den = 10;  end
      endcase
      ch1 = (ch0 * num) / den + $urandom_range(0, 2) - 1;
    end
    if (ch1 < 0) begin
      ch1 = 0;
    end
    if (ch1 > 65535) begin
      ch1 = 65535;
    end
    return sample_word(ch0, ch1);
  endfunction

  task automatic send_sample(logic [31:0] word);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_sample(word);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      sb.check_result(out_tdata[ltl_pkg::LUX_W-1:0], out_tuser);
    end
  end

  // result side back-pressure
  initial begin
    int stall;
    int taken;
    bit steady;
    taken  = 0;
    steady = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (taken % 80 == 0) begin
        steady = ($urandom_range(0, 3) == 0);
      end
      stall = steady ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      taken++;
    end
  end

  initial begin
    logic [31:0] corner_words [$];
    sb        = new();
    tx_steady = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    corner_words.push_back(sample_word(0, 0));
    corner_words.push_back(sample_word(0, 1));
    corner_words.push_back(sample_word(0, 65535));
    corner_words.push_back(sample_word(1, 0));
    corner_words.push_back(sample_word(65535, 0));
    corner_words.push_back(sample_word(65535, 65535));
    corner_words.push_back(sample_word(65535, 1));
    corner_words.push_back(sample_word(1, 1));
    corner_words.push_back(sample_word(2, 1));
    corner_words.push_back(sample_word(65535, 32767));
    corner_words.push_back(sample_word(65534, 32767));
    corner_words.push_back(sample_word(65535, 32768));
    corner_words.push_back(sample_word(100, 61));
    corner_words.push_back(sample_word(100, 62));
    corner_words.push_back(sample_word(5, 4));
    corner_words.push_back(sample_word(40000, 32001));
    corner_words.push_back(sample_word(10, 13));
    corner_words.push_back(sample_word(10, 14));
    corner_words.push_back(sample_word(1, 2));
    corner_words.push_back(sample_word(16'h00ff, 16'h00ff));
    corner_words.push_back(sample_word(16'hff00, 16'h00ff));
    corner_words.push_back(32'hffff_ffff);
    corner_words.push_back(32'h0000_0000);
    foreach (corner_words[i]) begin
      send_sample(corner_words[i]);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 100 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
      end
      send_sample(random_sample());
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
design/ltl_pkg.sv
design/ltl_div.sv
design/two_channel_light_to_lux_unit.sv
sim/testbench.sv
